FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check cons in the same cycle as ante
`define ACS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// check cons in the cycle after ante
`define ACS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/acs_pkg.sv
package acs_pkg;

	localparam int MEMORY_BYTES_DEF = 256;

	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_READ    = 2'd1,
		REQ_EXEC    = 2'd2,
		REQ_RESTART = 2'd3
	} req_op_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_HALT    = 2'd1,
		STS_UNKNOWN = 2'd2,
		STS_IGNORED = 2'd3
	} status_t;

	localparam logic [7:0] OPC_NOP   = 8'h00;
	localparam logic [7:0] OPC_LOAD  = 8'h01;
	localparam logic [7:0] OPC_ADD   = 8'h02;
	localparam logic [7:0] OPC_STORE = 8'h03;
	localparam logic [7:0] OPC_JMP   = 8'h04;
	localparam logic [7:0] OPC_JZ    = 8'h05;
	localparam logic [7:0] OPC_PRINT = 8'h06;
	localparam logic [7:0] OPC_HALT  = 8'hFF;

	localparam logic [7:0] ADDR_N       = 8'hC0;
	localparam logic [7:0] ADDR_RESULT  = 8'hC1;
	localparam logic [7:0] ADDR_COUNTER = 8'hC2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_FETCH,
		ST_OPER,
		ST_DATA,
		ST_PR0,
		ST_PR1,
		ST_PR2,
		ST_FINISH
	} state_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] read_data;
		logic [7:0] program_counter;
		logic [7:0] accumulator;
		logic [7:0] opcode;
		logic       trace_valid;
		logic [7:0] trace_iteration;
		logic [7:0] trace_result;
		logic [7:0] trace_counter;
	} rsp_t;

endpackage

FILE: hw/rtl/acs_req_if.sv
interface acs_req_if;
	logic            valid;
	logic            ready;
	acs_pkg::req_op_t op;
	logic [7:0]      address;
	logic [7:0]      data;

	modport source (output valid, output op, output address, output data, input ready);
	modport sink (input valid, input op, input address, input data, output ready);
endinterface

FILE: hw/rtl/acs_rsp_if.sv
interface acs_rsp_if;
	logic             valid;
	logic             ready;
	acs_pkg::status_t status;
	logic [7:0]       read_data;
	logic [7:0]       program_counter;
	logic [7:0]       accumulator;
	logic [7:0]       opcode;
	logic             trace_valid;
	logic [7:0]       trace_iteration;
	logic [7:0]       trace_result;
	logic [7:0]       trace_counter;

	modport source (output valid, output status, output read_data, output program_counter,
		output accumulator, output opcode, output trace_valid, output trace_iteration,
		output trace_result, output trace_counter, input ready);
	modport sink (input valid, input status, input read_data, input program_counter,
		input accumulator, input opcode, input trace_valid, input trace_iteration,
		input trace_result, input trace_counter, output ready);
endinterface

FILE: hw/rtl/acs_ram.sv
module acs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = acs_pkg::MEMORY_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: hw/rtl/accumulator_cpu_step.sv
// Write, restart and ignored steps go straight to the response register; a read reads memory;
// an executed step fetches the opcode, then the operand (LOAD/ADD/STORE/JMP/JZ) and the data
// (LOAD/ADD), or reads N, RESULT and COUNTER (PRINT); one memory read port, one read a cycle.
// One request at a time: the next is taken once the current one is in the response register,
// which waits while an earlier response is stalled. Reset: arst_n clears CPU registers and
// control, then a clearing pass zeroes all MEMORY_BYTES entries, one per cycle, req.ready low.
module accumulator_cpu_step #(
	parameter int MEMORY_BYTES = acs_pkg::MEMORY_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	acs_req_if.sink   req,
	acs_rsp_if.source rsp
);
	localparam int AW = $clog2(MEMORY_BYTES);

	acs_pkg::state_t st_q, st_d;
	logic [7:0]      pc_q, pc_d;
	logic [7:0]      acc_q, acc_d;
	logic [7:0]      instr_q, instr_d;
	logic            stopped_q, stopped_d;
	logic [AW-1:0]   clr_q, clr_d;
	logic            out_valid_q, out_valid_d;
	logic [7:0]      n_q, n_d;
	acs_pkg::rsp_t   res_q, res_d;
	acs_pkg::rsp_t   out_q, out_d;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [7:0]      wdata;
	logic [AW-1:0]   raddr;
	logic [7:0]      rdata;

	acs_ram #(
		.WIDTH(8),
		.DEPTH(MEMORY_BYTES)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		st_d        = st_q;
		pc_d        = pc_q;
		acc_d       = acc_q;
		instr_d     = instr_q;
		stopped_d   = stopped_q;
		clr_d       = clr_q;
		n_d         = n_q;
		res_d       = res_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !rsp.ready;
		we          = 1'b0;
		waddr       = pc_q[AW-1:0];
		wdata       = 8'd0;
		raddr       = pc_q[AW-1:0];
		req.ready   = 1'b0;

		case (st_q)
			acs_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				clr_d = clr_q + AW'(1);
				if (clr_q == AW'(MEMORY_BYTES - 1)) begin
					st_d = acs_pkg::ST_IDLE;
				end
			end
			acs_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					res_d        = '0;
					res_d.status = acs_pkg::STS_OK;
					st_d         = acs_pkg::ST_FINISH;
					case (req.op)
						acs_pkg::REQ_WRITE: begin
							we    = 1'b1;
							waddr = req.address[AW-1:0];
							wdata = req.data;
						end
						acs_pkg::REQ_READ: begin
							raddr = req.address[AW-1:0];
							st_d  = acs_pkg::ST_READ;
						end
						acs_pkg::REQ_RESTART: begin
							pc_d      = 8'd0;
							acc_d     = 8'd0;
							instr_d   = 8'd0;
							stopped_d = 1'b0;
						end
						acs_pkg::REQ_EXEC: begin
							if (stopped_q) begin
								res_d.status = acs_pkg::STS_IGNORED;
							end else begin
								pc_d = pc_q + 8'd1;
								st_d = acs_pkg::ST_FETCH;
							end
						end
						default: begin
							st_d = acs_pkg::ST_FINISH;
						end
					endcase
				end
			end
			acs_pkg::ST_READ: begin
				res_d.read_data = rdata;
				st_d            = acs_pkg::ST_FINISH;
			end
			acs_pkg::ST_FETCH: begin
				instr_d      = rdata;
				res_d.opcode = rdata;
				st_d         = acs_pkg::ST_FINISH;
				case (rdata)
					acs_pkg::OPC_NOP: begin
						st_d = acs_pkg::ST_FINISH;
					end
					acs_pkg::OPC_LOAD, acs_pkg::OPC_ADD, acs_pkg::OPC_STORE,
					acs_pkg::OPC_JMP, acs_pkg::OPC_JZ: begin
						pc_d = pc_q + 8'd1;
						st_d = acs_pkg::ST_OPER;
					end
					acs_pkg::OPC_PRINT: begin
						raddr             = acs_pkg::ADDR_N[AW-1:0];
						res_d.trace_valid = 1'b1;
						st_d              = acs_pkg::ST_PR0;
					end
					acs_pkg::OPC_HALT: begin
						res_d.status = acs_pkg::STS_HALT;
						stopped_d    = 1'b1;
					end
					default: begin
						res_d.status = acs_pkg::STS_UNKNOWN;
						stopped_d    = 1'b1;
					end
				endcase
			end
			acs_pkg::ST_OPER: begin
				st_d = acs_pkg::ST_FINISH;
				case (instr_q)
					acs_pkg::OPC_LOAD, acs_pkg::OPC_ADD: begin
						raddr = rdata[AW-1:0];
						st_d  = acs_pkg::ST_DATA;
					end
					acs_pkg::OPC_STORE: begin
						we    = 1'b1;
						waddr = rdata[AW-1:0];
						wdata = acc_q;
					end
					acs_pkg::OPC_JMP: begin
						pc_d = rdata;
					end
					acs_pkg::OPC_JZ: begin
						if (acc_q == 8'd0) begin
							pc_d = rdata;
						end
					end
					default: begin
						st_d = acs_pkg::ST_FINISH;
					end
				endcase
			end
			acs_pkg::ST_DATA: begin
				if (instr_q == acs_pkg::OPC_LOAD) begin
					acc_d = rdata;
				end else begin
					acc_d = acc_q + rdata;
				end
				st_d = acs_pkg::ST_FINISH;
			end
			acs_pkg::ST_PR0: begin
				n_d   = rdata;
				raddr = acs_pkg::ADDR_RESULT[AW-1:0];
				st_d  = acs_pkg::ST_PR1;
			end
			acs_pkg::ST_PR1: begin
				res_d.trace_result = rdata;
				raddr              = acs_pkg::ADDR_COUNTER[AW-1:0];
				st_d               = acs_pkg::ST_PR2;
			end
			acs_pkg::ST_PR2: begin
				res_d.trace_counter   = rdata;
				res_d.trace_iteration = n_q - rdata + 8'd1;
				st_d                  = acs_pkg::ST_FINISH;
			end
			acs_pkg::ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_d                 = res_q;
					out_d.program_counter = pc_q;
					out_d.accumulator     = acc_q;
					out_valid_d           = 1'b1;
					st_d                  = acs_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = acs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= acs_pkg::ST_CLEAR;
			pc_q        <= 8'd0;
			acc_q       <= 8'd0;
			instr_q     <= 8'd0;
			stopped_q   <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			pc_q        <= pc_d;
			acc_q       <= acc_d;
			instr_q     <= instr_d;
			stopped_q   <= stopped_d;
			clr_q       <= clr_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q   <= n_d;
		res_q <= res_d;
		out_q <= out_d;
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_q.status;
	assign rsp.read_data       = out_q.read_data;
	assign rsp.program_counter = out_q.program_counter;
	assign rsp.accumulator     = out_q.accumulator;
	assign rsp.opcode          = out_q.opcode;
	assign rsp.trace_valid     = out_q.trace_valid;
	assign rsp.trace_iteration = out_q.trace_iteration;
	assign rsp.trace_result    = out_q.trace_result;
	assign rsp.trace_counter   = out_q.trace_counter;
endmodule

FILE: hw/rtl/acs_checker.sv
`include "assert_macros.svh"

module acs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input acs_pkg::status_t status,
	input logic [7:0]       opcode,
	input logic             trace_valid,
	input logic [7:0]       trace_result
);
	`ACS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(trace_result), "response dropped or changed while stalled")
	`ACS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken while one is in progress")
	`ACS_ASSERT_NOW(a_ignored_no_fetch, out_valid && status == acs_pkg::STS_IGNORED, opcode == 8'd0, "ignored step reports an opcode")
	`ACS_ASSERT_NOW(a_trace_is_print, out_valid && trace_valid, opcode == acs_pkg::OPC_PRINT && status == acs_pkg::STS_OK, "trace without print opcode")
endmodule

bind accumulator_cpu_step acs_checker u_acs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.status      (rsp.status),
	.opcode      (rsp.opcode),
	.trace_valid (rsp.trace_valid),
	.trace_result(rsp.trace_result)
);

FILE: tb/sv/cpu_response_checker.sv
`timescale 1ns / 100ps

module cpu_response_checker (
	input  logic clk,
	input  logic arst_n,
	acs_req_if   req,
	acs_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding
);
	import acs_pkg::*;

	logic [7:0] mem_image [0:MEMORY_BYTES_DEF-1];
	logic [7:0] acc_q;
	logic [7:0] pc_q;
	logic [7:0] ir_q;
	logic       halted_q;
	rsp_t       expected_responses [$];

	function automatic logic [7:0] fetch_byte();
		logic [7:0] b;
		b = mem_image[pc_q];
		pc_q = pc_q + 8'd1;
		return b;
	endfunction

	function automatic rsp_t predict_cpu_response(input req_op_t op, input logic [7:0] addr,
		input logic [7:0] data);
		rsp_t       r;
		logic [7:0] operand;
		r = '0;
		case (op)
		REQ_WRITE: mem_image[addr] = data;
		REQ_READ: r.read_data = mem_image[addr];
		REQ_RESTART: begin
			pc_q = 8'h00;
			acc_q = 8'h00;
			ir_q = 8'h00;
			halted_q = 1'b0;
		end
		default: begin
			if (halted_q) begin
				r.status = STS_IGNORED;
			end else begin
				ir_q = fetch_byte();
				r.opcode = ir_q;
				case (ir_q)
				OPC_NOP: ;
				OPC_LOAD: begin
					operand = fetch_byte();
					acc_q = mem_image[operand];
				end
				OPC_ADD: begin
					operand = fetch_byte();
					acc_q = acc_q + mem_image[operand];
				end
				OPC_STORE: begin
					operand = fetch_byte();
					mem_image[operand] = acc_q;
				end
				OPC_JMP: begin
					operand = fetch_byte();
					pc_q = operand;
				end
				OPC_JZ: begin
					operand = fetch_byte();
					if (acc_q == 8'h00)
						pc_q = operand;
				end
				OPC_PRINT: begin
					r.trace_valid = 1'b1;
					r.trace_result = mem_image[ADDR_RESULT];
					r.trace_counter = mem_image[ADDR_COUNTER];
					r.trace_iteration = mem_image[ADDR_N] - mem_image[ADDR_COUNTER] + 8'd1;
				end
				OPC_HALT: begin
					r.status = STS_HALT;
					halted_q = 1'b1;
				end
				default: begin
					r.status = STS_UNKNOWN;
					halted_q = 1'b1;
				end
				endcase
			end
		end
		endcase
		r.program_counter = pc_q;
		r.accumulator = acc_q;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < MEMORY_BYTES_DEF; i++)
				mem_image[i] = 8'h00;
			acc_q = 8'h00;
			pc_q = 8'h00;
			ir_q = 8'h00;
			halted_q = 1'b0;
			expected_responses.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_responses.size() == 0) begin
					$error("response with no request outstanding");
					mismatches++;
				end else begin
					want = expected_responses.pop_front();
					check_field("status", 8'(want.status), 8'(rsp.status));
					check_field("read_data", want.read_data, rsp.read_data);
					check_field("program_counter", want.program_counter, rsp.program_counter);
					check_field("accumulator", want.accumulator, rsp.accumulator);
					check_field("opcode", want.opcode, rsp.opcode);
					check_field("trace_valid", 8'(want.trace_valid), 8'(rsp.trace_valid));
					check_field("trace_iteration", want.trace_iteration, rsp.trace_iteration);
					check_field("trace_result", want.trace_result, rsp.trace_result);
					check_field("trace_counter", want.trace_counter, rsp.trace_counter);
				end
			end
			if (req.valid && req.ready)
				expected_responses.push_back(predict_cpu_response(req.op, req.address, req.data));
			outstanding = expected_responses.size();
		end
	end

endmodule

FILE: tb/sv/tb_accumulator_cpu_step.sv
`timescale 1ns / 100ps

module tb_accumulator_cpu_step;
	import acs_pkg::*;

	localparam int         RANDOM_ITEMS   = 450;
	localparam int         CALM_TAIL      = 60;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam logic [7:0] OPC_UNDEFINED  = 8'h07;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	int   mismatches;
	int   outstanding;
	int   quiet_cycles = 0;
	int   stall_left = 0;
	int   items_sent = 0;
	int   total_items;

	acs_req_if req_ch ();
	acs_rsp_if rsp_ch ();

	accumulator_cpu_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	cpu_response_checker response_check (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (stall_left > 0)
			stall_left = stall_left - 1;
		else if (!calm && $urandom_range(0, 4) == 0)
			stall_left = $urandom_range(1, 11);
		rsp_ch.ready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("accumulator_cpu_step regression: fail");
			$finish;
		end
	end

	task automatic send_request(input req_op_t op, input logic [7:0] addr, input logic [7:0] data);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 11);
		repeat (gap) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.address <= addr;
		req_ch.data <= data;
		do
			@(posedge clk);
		while (!req_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_opcode();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick >= 17)
			return 8'($urandom);
		case (pick % 8)
		0: return OPC_NOP;
		1: return OPC_LOAD;
		2: return OPC_ADD;
		3: return OPC_STORE;
		4: return OPC_JMP;
		5: return OPC_JZ;
		6: return OPC_PRINT;
		default: return OPC_HALT;
		endcase
	endfunction

	function automatic logic [7:0] pick_data_address();
		case ($urandom_range(0, 4))
		0: return ADDR_N;
		1: return ADDR_RESULT;
		2: return ADDR_COUNTER;
		default: return 8'($urandom);
		endcase
	endfunction

	task automatic run_program_episode();
		logic [7:0] base;
		logic [7:0] cursor;
		logic [7:0] opc;
		logic [7:0] arg;
		int         count;
		case ($urandom_range(0, 3))
		0: base = 8'($urandom);
		1: base = 8'($urandom_range(250, 255));
		default: base = 8'h00;
		endcase
		if (base != 8'h00) begin
			send_request(REQ_WRITE, 8'h00, OPC_JMP);
			send_request(REQ_WRITE, 8'h01, base);
		end
		cursor = base;
		count = $urandom_range(2, 8);
		repeat (count) begin
			opc = pick_opcode();
			send_request(REQ_WRITE, cursor, opc);
			cursor++;
			if (opc >= OPC_LOAD && opc <= OPC_JZ) begin
				if (opc == OPC_JMP || opc == OPC_JZ)
					arg = base + 8'($urandom_range(0, 2 * count));
				else
					arg = pick_data_address();
				send_request(REQ_WRITE, cursor, arg);
				cursor++;
			end
		end
		if ($urandom_range(0, 1) == 0) begin
			send_request(REQ_WRITE, ADDR_N, 8'($urandom));
			send_request(REQ_WRITE, ADDR_COUNTER, 8'($urandom));
		end
		send_request(REQ_RESTART, 8'($urandom), 8'($urandom));
		repeat ($urandom_range(3, 14)) begin
			case ($urandom_range(0, 9))
			0: send_request(REQ_READ, pick_data_address(), 8'($urandom));
			1: send_request(REQ_WRITE, pick_data_address(), 8'($urandom));
			default: send_request(REQ_EXEC, 8'($urandom), 8'($urandom));
			endcase
		end
	endtask

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.op <= REQ_WRITE;
		req_ch.address <= 8'h00;
		req_ch.data <= 8'h00;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// load a short program: load, add, store, print, jz, jmp to the top byte,
		// add with its operand wrapped to address zero, then halt
		send_request(REQ_READ, 8'hFF, 8'h00);
		send_request(REQ_WRITE, 8'h00, OPC_LOAD);
		send_request(REQ_WRITE, 8'h01, OPC_HALT);
		send_request(REQ_WRITE, 8'h02, OPC_ADD);
		send_request(REQ_WRITE, 8'h03, 8'hFF);
		send_request(REQ_WRITE, 8'h04, OPC_STORE);
		send_request(REQ_WRITE, 8'h05, ADDR_RESULT);
		send_request(REQ_WRITE, 8'h06, OPC_PRINT);
		send_request(REQ_WRITE, 8'h07, OPC_JZ);
		send_request(REQ_WRITE, 8'h08, 8'h00);
		send_request(REQ_WRITE, 8'h09, OPC_JMP);
		send_request(REQ_WRITE, 8'h0A, 8'hFF);
		send_request(REQ_WRITE, 8'hFF, OPC_ADD);
		repeat (8)
			send_request(REQ_EXEC, 8'h00, 8'h00);
		send_request(REQ_EXEC, 8'hFF, 8'hFF);
		send_request(REQ_READ, ADDR_RESULT, 8'h00);
		send_request(REQ_WRITE, 8'h00, OPC_UNDEFINED);
		send_request(REQ_RESTART, 8'h00, 8'h00);
		send_request(REQ_EXEC, 8'h00, 8'h00);
		send_request(REQ_RESTART, 8'hFF, 8'hFF);

		// hold off until the directed requests have all answered
		wait_idle();

		total_items = items_sent + RANDOM_ITEMS;
		while (items_sent < total_items) begin
			calm = (items_sent > total_items - CALM_TAIL);
			if ($urandom_range(0, 9) < 8)
				run_program_episode();
			else
				repeat ($urandom_range(1, 6))
					send_request(req_op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
			if (!calm && $urandom_range(0, 7) == 0)
				wait_idle();
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("accumulator_cpu_step regression: pass");
		else
			$display("accumulator_cpu_step regression: fail");
		$finish;
	end

endmodule
